// ===== rtl/u2d_pkg.sv =====
package u2d_pkg;

    localparam int VALUE_W   = 64;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 6;
    localparam int STEP_W    = 8;
    localparam int REM_X_W   = DIGIT_W + STEP_W;
    localparam int PROD_W    = 2 * REM_X_W;
    localparam int RECIP_SH  = 15;

    localparam logic [REM_X_W-1:0] RECIP_TEN  = REM_X_W'(3277);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== rtl/u2d_div10.sv =====
module u2d_div10 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [u2d_pkg::VALUE_W-1:0]  i_value,
    output u2d_pkg::t_div_status         o_status,
    output logic [u2d_pkg::VALUE_W-1:0]  o_quot,
    output logic [u2d_pkg::DIGIT_W-1:0]  o_rem
);

    localparam int STEPS = u2d_pkg::VALUE_W / u2d_pkg::STEP_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [u2d_pkg::VALUE_W-1:0] r_work;
    logic [u2d_pkg::DIGIT_W-1:0] r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [u2d_pkg::REM_X_W-1:0] w_x;
    logic [u2d_pkg::PROD_W-1:0]  w_prod;
    logic [u2d_pkg::STEP_W-1:0]  w_q;
    logic [u2d_pkg::REM_X_W-1:0] w_q10;
    logic [u2d_pkg::REM_X_W-1:0] w_r;

    // Each step divides the remainder joined with the next byte by ten.
    always_comb begin
        w_x    = {r_rem, r_work[u2d_pkg::VALUE_W-1 -: u2d_pkg::STEP_W]};
        w_prod = u2d_pkg::PROD_W'(w_x) * u2d_pkg::PROD_W'(u2d_pkg::RECIP_TEN);
        w_q    = w_prod[u2d_pkg::RECIP_SH +: u2d_pkg::STEP_W];
        w_q10  = {1'b0, w_q, 3'b000} + {3'b000, w_q, 1'b0};
        w_r    = w_x - w_q10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_value;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= {r_work[u2d_pkg::VALUE_W-u2d_pkg::STEP_W-1:0], w_q};
            r_rem  <= w_r[u2d_pkg::DIGIT_W-1:0];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_work;
    assign o_rem         = r_rem;

endmodule

// ===== rtl/u2d_digit_store.sv =====
module u2d_digit_store #(
    parameter int DEPTH  = 20,
    parameter int ADDR_W = 5
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [u2d_pkg::DIGIT_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [u2d_pkg::DIGIT_W-1:0]  o_rdata
);

    logic [u2d_pkg::DIGIT_W-1:0] r_mem [DEPTH];
    logic [u2d_pkg::DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/uint64_to_decimal_ascii.sv =====
// Converts one unsigned 64-bit item into decimal ASCII characters, most significant first.
// Each digit comes from the byte-serial divide-by-ten unit (8 steps plus one handoff).
// Each character then passes through a store read state and an output state, plus any output stall.
// No new item is accepted until the last character of the current item has been taken.
// Reset is synchronous and active low; it idles the sequencer and drops o_valid.
module uint64_to_decimal_ascii #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [u2d_pkg::VALUE_W-1:0]     i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [u2d_pkg::CHAR_W-1:0]      o_ascii_char,
    output logic                            o_last
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                         w_start;
    logic [u2d_pkg::VALUE_W-1:0]  w_start_value;
    u2d_pkg::t_div_status         w_div_status;
    logic [u2d_pkg::VALUE_W-1:0]  w_quot;
    logic [u2d_pkg::DIGIT_W-1:0]  w_rem;
    logic                         w_we;
    logic                         w_re;
    logic [CNT_W-1:0]             w_count_inc;
    logic [CNT_W-1:0]             w_count_dec;
    logic [u2d_pkg::DIGIT_W-1:0]  w_rdata;

    assign w_count_inc = r_count + 1'b1;
    assign w_count_dec = r_count - 1'b1;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        w_start       = 1'b0;
        w_start_value = i_value;
        w_we          = 1'b0;
        w_re          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_start = 1'b1;
                    n_count = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_status.done) begin
                    w_we    = 1'b1;
                    n_count = w_count_inc;
                    if ((w_quot != '0) && (w_count_inc < CNT_W'(MAX_DIGITS))) begin
                        w_start       = 1'b1;
                        w_start_value = w_quot;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                w_re    = 1'b1;
                n_count = w_count_dec;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_ready) begin
                    if (r_count == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    u2d_div10 u_div10 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (w_start_value),
        .o_status (w_div_status),
        .o_quot   (w_quot),
        .o_rem    (w_rem)
    );

    u2d_digit_store #(
        .DEPTH  (MAX_DIGITS),
        .ADDR_W (ADDR_W)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (w_rem),
        .i_re    (w_re),
        .i_raddr (w_count_dec[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_EMIT);
    assign o_ascii_char = u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_W'(w_rdata);
    assign o_last       = (r_count == '0);

endmodule
